// ===== hdl/lzwe_pkg.sv =====
// Shared types, constants and the hash function of the LZW byte encoder.
// Used by every encoder module but lzwe_ram; depends on nothing else.
package lzwe_pkg;

    localparam int unsigned CODE_BITS  = 12;
    localparam int unsigned NF_W       = CODE_BITS + 1;
    localparam int unsigned HASH_BITS  = CODE_BITS + 1;
    localparam int unsigned FIRST_FREE = 256;
    localparam int unsigned CODE_LIMIT = 1 << CODE_BITS;
    localparam int unsigned DICT_DEPTH = CODE_LIMIT - FIRST_FREE;
    localparam int unsigned HASH_DEPTH = 1 << HASH_BITS;

    typedef logic [CODE_BITS-1:0] t_code;
    typedef logic [NF_W-1:0]      t_next;
    typedef logic [HASH_BITS-1:0] t_slot;
    typedef logic [7:0]           t_sym;

    localparam t_next FIRST_FREE_N = t_next'(FIRST_FREE);
    localparam t_next CODE_LIMIT_N = t_next'(CODE_LIMIT);

    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // One dictionary entry, plus the hash slot that points at it.
    typedef struct packed {
        t_code prefix;
        t_sym  sym;
        t_slot slot;
    } t_dict_entry;

    typedef struct packed {
        logic        hash_rd;
        t_slot       hash_addr;
        logic        dict_rd;
        t_code       dict_code;
        logic        wr;
        t_slot       wr_slot;
        t_next       wr_code;
        t_dict_entry wr_entry;
    } t_dict_req;

    typedef struct packed {
        logic  cand_live;
        logic  slot_match;
        logic  key_match;
        t_code cand;
    } t_dict_stat;

    function automatic t_slot hash_slot(input t_code prefix, input t_sym sym);
        t_slot h;
        h = {1'b0, prefix} ^ {sym, {(HASH_BITS-8){1'b0}}};
        return h;
    endfunction

endpackage

// ===== hdl/lzwe_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
module lzwe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/lzwe_dict.sv =====
// Dictionary storage: hash table of codes and the code-indexed entry table.
// Depends on lzwe_pkg and lzwe_ram.
module lzwe_dict (
    input  logic                  i_clk,
    input  lzwe_pkg::t_dict_req   i_req,
    input  lzwe_pkg::t_next       i_next_free,
    input  lzwe_pkg::t_code       i_prefix,
    input  lzwe_pkg::t_sym        i_sym,
    input  lzwe_pkg::t_slot       i_slot,
    output lzwe_pkg::t_dict_stat  o_stat
);

    lzwe_pkg::t_code       hash_q;
    lzwe_pkg::t_dict_entry dict_q;
    lzwe_pkg::t_code       dict_rd_addr;
    lzwe_pkg::t_next       wr_index;
    lzwe_pkg::t_next       cand_ext;

    assign dict_rd_addr = i_req.dict_code - lzwe_pkg::t_code'(lzwe_pkg::FIRST_FREE);
    assign wr_index     = i_req.wr_code - lzwe_pkg::FIRST_FREE_N;

    lzwe_ram #(
        .WIDTH (lzwe_pkg::CODE_BITS),
        .DEPTH (lzwe_pkg::HASH_DEPTH)
    ) u_hash_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_req.wr),
        .i_wr_addr (i_req.wr_slot),
        .i_wr_data (i_req.wr_code[lzwe_pkg::CODE_BITS-1:0]),
        .i_rd_en   (i_req.hash_rd),
        .i_rd_addr (i_req.hash_addr),
        .o_rd_data (hash_q)
    );

    lzwe_ram #(
        .WIDTH ($bits(lzwe_pkg::t_dict_entry)),
        .DEPTH (lzwe_pkg::DICT_DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_req.wr),
        .i_wr_addr (wr_index[lzwe_pkg::CODE_BITS-1:0]),
        .i_wr_data (i_req.wr_entry),
        .i_rd_en   (i_req.dict_rd),
        .i_rd_addr (dict_rd_addr),
        .o_rd_data (dict_q)
    );

    // A slot is occupied only when it names a code of the current stream
    // and that code's entry points back at the same slot. Stale contents
    // from earlier streams or from power-up fail one of the two tests.
    assign cand_ext = {1'b0, hash_q};

    always_comb begin
        o_stat.cand       = hash_q;
        o_stat.cand_live  = (cand_ext >= lzwe_pkg::FIRST_FREE_N) && (cand_ext < i_next_free);
        o_stat.slot_match = (dict_q.slot == i_slot);
        o_stat.key_match  = (dict_q.prefix == i_prefix) && (dict_q.sym == i_sym);
    end

endmodule

// ===== hdl/lzwe_outbuf.sv =====
// Output register for emitted codes; frees the encoder while a code waits.
// Depends on lzwe_pkg.
module lzwe_outbuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lzwe_pkg::t_code i_code,
    input  logic            i_last,
    input  logic            i_stall,
    output logic            o_ready,
    output logic            o_valid,
    output lzwe_pkg::t_code o_code,
    output logic            o_last
);

    logic            r_valid;
    lzwe_pkg::t_code r_code;
    logic            r_last;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            r_code <= i_code;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_code  = r_code;
    assign o_last  = r_last;

endmodule

// ===== hdl/lzw_byte_encoder_core.sv =====
// LZW byte encoder top level: control sequencer, dictionary memories, output register.
// Finish or a first byte is done while idle; finish with a pending code also emits it.
// A byte with a prefix reads the hash table, then the entry table on a live slot, probing
// the next slot while a slot holds another key; a miss emits the pending code. The input
// stalls until the byte is done, and a code waits while the output register is full and stalled.
// Reset is synchronous and clears control only; memories need no clearing pass.
module lzw_byte_encoder_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_operation,
    input  logic [7:0]      i_data_byte,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [11:0]     o_code,
    output logic            o_last
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_HREAD = 4'b0010,
        S_DREAD = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state                r_state,      n_state;
    lzwe_pkg::t_next       r_next_free,  n_next_free;
    lzwe_pkg::t_code       r_pend_code,  n_pend_code;
    logic                  r_pend_valid, n_pend_valid;
    lzwe_pkg::t_sym        r_sym,        n_sym;
    lzwe_pkg::t_slot       r_slot,       n_slot;
    lzwe_pkg::t_code       r_cand,       n_cand;
    lzwe_pkg::t_code       r_res_code,   n_res_code;
    logic                  r_res_last,   n_res_last;

    lzwe_pkg::t_dict_req   dict_req;
    lzwe_pkg::t_dict_stat  dict_stat;
    lzwe_pkg::t_slot       first_slot;
    logic                  miss;
    logic                  push;
    logic                  buf_ready;

    assign first_slot = lzwe_pkg::hash_slot(r_pend_code, i_data_byte);
    assign o_stall    = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_next_free  = r_next_free;
        n_pend_code  = r_pend_code;
        n_pend_valid = r_pend_valid;
        n_sym        = r_sym;
        n_slot       = r_slot;
        n_cand       = r_cand;
        n_res_code   = r_res_code;
        n_res_last   = r_res_last;
        dict_req     = '0;
        miss         = 1'b0;
        push         = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_operation == lzwe_pkg::OP_FINISH) begin
                        if (r_pend_valid) begin
                            n_res_code = r_pend_code;
                            n_res_last = 1'b1;
                            n_state    = S_EMIT;
                        end
                        n_next_free  = lzwe_pkg::FIRST_FREE_N;
                        n_pend_code  = '0;
                        n_pend_valid = 1'b0;
                    end else if (!r_pend_valid) begin
                        n_pend_code  = lzwe_pkg::t_code'(i_data_byte);
                        n_pend_valid = 1'b1;
                    end else begin
                        n_sym              = i_data_byte;
                        n_slot             = first_slot;
                        dict_req.hash_rd   = 1'b1;
                        dict_req.hash_addr = first_slot;
                        n_state            = S_HREAD;
                    end
                end
            end
            S_HREAD: begin
                // An unknown or stale slot falls to the empty-slot branch.
                if (dict_stat.cand_live) begin
                    dict_req.dict_rd   = 1'b1;
                    dict_req.dict_code = dict_stat.cand;
                    n_cand             = dict_stat.cand;
                    n_state            = S_DREAD;
                end else begin
                    miss = 1'b1;
                end
            end
            S_DREAD: begin
                if (dict_stat.slot_match && dict_stat.key_match) begin
                    n_pend_code = r_cand;
                    n_state     = S_IDLE;
                end else if (dict_stat.slot_match) begin
                    // Occupied by another key: linear probe to the next slot.
                    n_slot             = r_slot + 1'b1;
                    dict_req.hash_rd   = 1'b1;
                    dict_req.hash_addr = r_slot + 1'b1;
                    n_state            = S_HREAD;
                end else begin
                    miss = 1'b1;
                end
            end
            S_EMIT: begin
                push = 1'b1;
                if (buf_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (miss) begin
            n_res_code = r_pend_code;
            n_res_last = 1'b0;
            if (r_next_free < lzwe_pkg::CODE_LIMIT_N) begin
                dict_req.wr              = 1'b1;
                dict_req.wr_slot         = r_slot;
                dict_req.wr_code         = r_next_free;
                dict_req.wr_entry.prefix = r_pend_code;
                dict_req.wr_entry.sym    = r_sym;
                dict_req.wr_entry.slot   = r_slot;
                n_next_free              = r_next_free + 1'b1;
            end
            n_pend_code = lzwe_pkg::t_code'(r_sym);
            n_state     = S_EMIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_next_free  <= lzwe_pkg::FIRST_FREE_N;
            r_pend_code  <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_next_free  <= n_next_free;
            r_pend_code  <= n_pend_code;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym      <= n_sym;
        r_slot     <= n_slot;
        r_cand     <= n_cand;
        r_res_code <= n_res_code;
        r_res_last <= n_res_last;
    end

    lzwe_dict u_dict (
        .i_clk       (i_clk),
        .i_req       (dict_req),
        .i_next_free (r_next_free),
        .i_prefix    (r_pend_code),
        .i_sym       (r_sym),
        .i_slot      (r_slot),
        .o_stat      (dict_stat)
    );

    lzwe_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_code  (r_res_code),
        .i_last  (r_res_last),
        .i_stall (i_stall),
        .o_ready (buf_ready),
        .o_valid (o_valid),
        .o_code  (o_code),
        .o_last  (o_last)
    );

endmodule

// ===== hdl/lzwe_checker.sv =====
// Port-level checks for the LZW byte encoder, bound to the top level.
// Depends on lzwe_pkg and lzw_byte_encoder_core.
module lzwe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_operation,
    input logic        o_valid,
    input logic        i_stall,
    input logic [11:0] o_code,
    input logic        o_last
);

    // A stalled result beat holds its code and marker.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_code) && $stable(o_last))
        else $error("stalled result beat changed");

    // Reset empties the output register.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Reset returns the sequencer to idle, ready for a beat.
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

    // A data beat taken while no result is out cannot yield a last-marked result
    // in the very next cycle.
    a_no_early_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_operation == lzwe_pkg::OP_DATA) && !o_valid
        |=> !(o_valid && o_last))
        else $error("last code without a finish beat");

endmodule

bind lzw_byte_encoder_core lzwe_checker u_lzwe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_operation (i_operation),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_code      (o_code),
    .o_last      (o_last)
);

// ===== tb/sv/lzw_byte_encoder_core_tb.sv =====
// Self-checking testbench for lzw_byte_encoder_core: a clocked driver, a clocked monitor and
// a code predictor that tracks the dictionary, the pending prefix and the next free code.
// Depends on lzwe_pkg and lzw_byte_encoder_core only.
`timescale 1ns / 100ps

module lzw_byte_encoder_core_tb;

    typedef struct {
        bit             hold;      // Marks a pause until every expected code has come.
        logic           op;
        lzwe_pkg::t_sym data;
    } t_stim_beat;

    typedef struct {
        lzwe_pkg::t_code code;
        logic            last;
    } t_lzw_code;

    localparam int RANDOM_BEATS = 1100;
    localparam int FILL_BYTES   = 200;
    localparam int REPLAY_BYTES = 20;
    localparam int PAUSE_CYCLES = 40;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_operation = lzwe_pkg::OP_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [11:0] o_code;
    logic        o_last;

    t_stim_beat stim_beats[$];
    t_lzw_code  expected_codes[$];

    // Predictor state.
    lzwe_pkg::t_code dict_map [logic [19:0]];
    lzwe_pkg::t_next next_free   = lzwe_pkg::FIRST_FREE_N;
    lzwe_pkg::t_code pend_code   = '0;
    logic            pend_valid  = 1'b0;

    int errors       = 0;
    int beats_in     = 0;
    int codes_out    = 0;
    int streams_done = 0;
    int full_emits   = 0;
    int pauses       = 0;
    int random_beats = 0;
    int peak_free    = int'(lzwe_pkg::FIRST_FREE);

    int gap_left   = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    t_stim_beat head;
    t_lzw_code  got;

    lzw_byte_encoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_code      (o_code),
        .o_last      (o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic push_beat(input logic op, input lzwe_pkg::t_sym data);
        t_stim_beat s;
        s.hold = 1'b0;
        s.op   = op;
        s.data = data;
        stim_beats.push_back(s);
    endtask

    task automatic push_hold();
        t_stim_beat s;
        s.hold = 1'b1;
        s.op   = lzwe_pkg::OP_DATA;
        s.data = '0;
        stim_beats.push_back(s);
    endtask

    // One stream of random length and flavor, closed by a finish.
    task automatic add_random_stream();
        int             len;
        int             mode;
        int             plen;
        lzwe_pkg::t_sym base;
        lzwe_pkg::t_sym pat[6];
        lzwe_pkg::t_sym b;
        case ($urandom_range(0, 9))
            0: len = $urandom_range(0, 2);
            1: len = $urandom_range(60, 160);
            default: len = $urandom_range(3, 40);
        endcase
        mode = $urandom_range(0, 2);
        base = lzwe_pkg::t_sym'($urandom);
        plen = $urandom_range(1, 6);
        for (int i = 0; i < 6; i++) pat[i] = lzwe_pkg::t_sym'($urandom);
        for (int i = 0; i < len; i++) begin
            case (mode)
                0: b = lzwe_pkg::t_sym'($urandom);
                1: b = base + lzwe_pkg::t_sym'($urandom_range(0, 3));
                default: b = ($urandom_range(0, 15) == 0) ? lzwe_pkg::t_sym'($urandom)
                                                          : pat[i % plen];
            endcase
            push_beat(lzwe_pkg::OP_DATA, b);
        end
        push_beat(lzwe_pkg::OP_FINISH, lzwe_pkg::t_sym'($urandom));
        random_beats += len + 1;
    endtask

    // Computes the code, if any, that one accepted beat produces.
    task automatic encode_beat(input logic op, input lzwe_pkg::t_sym b);
        t_lzw_code   c;
        logic [19:0] key;
        key = {pend_code, b};
        if (op == lzwe_pkg::OP_FINISH) begin
            if (pend_valid) begin
                c.code = pend_code;
                c.last = 1'b1;
                expected_codes.push_back(c);
            end
            dict_map.delete();
            next_free  = lzwe_pkg::FIRST_FREE_N;
            pend_code  = '0;
            pend_valid = 1'b0;
            streams_done++;
        end else if (!pend_valid) begin
            pend_code  = lzwe_pkg::t_code'(b);
            pend_valid = 1'b1;
        end else if (dict_map.exists(key)) begin
            pend_code = dict_map[key];
        end else begin
            c.code = pend_code;
            c.last = 1'b0;
            expected_codes.push_back(c);
            if (next_free < lzwe_pkg::CODE_LIMIT_N) begin
                dict_map[key] = lzwe_pkg::t_code'(next_free);
                next_free++;
                if (int'(next_free) > peak_free) peak_free = int'(next_free);
            end else begin
                full_emits++;
            end
            pend_code = lzwe_pkg::t_code'(b);
        end
    endtask

    // Driver: bursts of beats with random gaps, and pauses where a hold marker sits.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                encode_beat(i_operation, i_data_byte);
                beats_in++;
            end
            if (i_valid && o_stall) begin
                // A stalled beat stays on the bus unchanged.
            end else if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (stim_beats.size() == 0) begin
                i_valid <= 1'b0;
            end else if (stim_beats[0].hold) begin
                i_valid <= 1'b0;
                if (expected_codes.size() == 0) begin
                    void'(stim_beats.pop_front());
                    gap_left = PAUSE_CYCLES;
                    pauses++;
                end
            end else begin
                head = stim_beats.pop_front();
                i_valid     <= 1'b1;
                i_operation <= head.op;
                i_data_byte <= head.data;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 9))
                        0, 1:    gap_left = $urandom_range(4, 12);
                        2:       gap_left = 0;
                        default: gap_left = $urandom_range(0, 3);
                    endcase
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // Monitor: checks each accepted code and drives the receiver stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_codes.size() == 0) begin
                    $display("%0t: unexpected code, expected none, actual code %0d last %0b",
                             $time, o_code, o_last);
                    errors++;
                end else begin
                    got = expected_codes.pop_front();
                    codes_out++;
                    if (o_code !== got.code) begin
                        $display("%0t: code mismatch, expected %0d, actual %0d",
                                 $time, got.code, o_code);
                        errors++;
                    end
                    if (o_last !== got.last) begin
                        $display("%0t: last mismatch, expected %0b, actual %0b",
                                 $time, got.last, o_last);
                        errors++;
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 160);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 2) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= ($urandom_range(0, 7) == 0) ? !i_stall : i_stall;
            endcase
        end
    end

    initial begin
        lzwe_pkg::t_sym fill[$];
        // Finish on an empty stream right after reset.
        push_beat(lzwe_pkg::OP_FINISH, 8'h00);
        // Extreme bytes, a dictionary hit, and a finish whose byte must be ignored.
        push_beat(lzwe_pkg::OP_DATA, 8'h00);
        push_beat(lzwe_pkg::OP_DATA, 8'hFF);
        push_beat(lzwe_pkg::OP_DATA, 8'hFF);
        push_beat(lzwe_pkg::OP_DATA, 8'hFF);
        push_beat(lzwe_pkg::OP_DATA, 8'hFF);
        push_beat(lzwe_pkg::OP_DATA, 8'h00);
        push_beat(lzwe_pkg::OP_FINISH, 8'hA5);
        // Two finishes in a row: the second sees an empty stream.
        push_beat(lzwe_pkg::OP_FINISH, 8'hFF);
        // A stream of a single byte.
        push_beat(lzwe_pkg::OP_DATA, 8'h5A);
        push_beat(lzwe_pkg::OP_FINISH, 8'h00);
        // Repeated pair that chains through dictionary codes.
        push_beat(lzwe_pkg::OP_DATA, 8'h41);
        push_beat(lzwe_pkg::OP_DATA, 8'h42);
        push_beat(lzwe_pkg::OP_DATA, 8'h41);
        push_beat(lzwe_pkg::OP_DATA, 8'h42);
        push_beat(lzwe_pkg::OP_DATA, 8'h41);
        push_beat(lzwe_pkg::OP_DATA, 8'h42);
        push_beat(lzwe_pkg::OP_DATA, 8'h41);
        push_beat(lzwe_pkg::OP_FINISH, 8'h3C);
        push_hold();

        while (random_beats < RANDOM_BEATS) begin
            add_random_stream();
            if ($urandom_range(0, 11) == 0) push_hold();
        end
        push_hold();

        // A longer random stream; replaying its start then hits the entries it made.
        for (int i = 0; i < FILL_BYTES; i++) fill.push_back(lzwe_pkg::t_sym'($urandom));
        foreach (fill[i]) push_beat(lzwe_pkg::OP_DATA, fill[i]);
        for (int i = 0; i < REPLAY_BYTES; i++) push_beat(lzwe_pkg::OP_DATA, fill[i]);
        push_beat(lzwe_pkg::OP_FINISH, lzwe_pkg::t_sym'($urandom));
        // The same start again must miss, since finish empties the dictionary.
        for (int i = 0; i < 20; i++) push_beat(lzwe_pkg::OP_DATA, fill[i]);
        push_beat(lzwe_pkg::OP_FINISH, lzwe_pkg::t_sym'($urandom));
        push_hold();
        for (int i = 0; i < 4; i++) add_random_stream();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_beats.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_codes.size() != 0) @(posedge i_clk);
        repeat (PAUSE_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats in %0d streams with %0d pauses; checked %0d codes.",
                 beats_in, streams_done, pauses, codes_out);
        $display("Dictionary grew to %0d codes; %0d codes came out while it was full.",
                 peak_free, full_emits);
        if (errors == 0 && expected_codes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d beats and %0d codes still pending.",
                 stim_beats.size(), expected_codes.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lzwe_pkg.sv
hdl/lzwe_ram.sv
hdl/lzwe_dict.sv
hdl/lzwe_outbuf.sv
hdl/lzw_byte_encoder_core.sv
hdl/lzwe_checker.sv
tb/sv/lzw_byte_encoder_core_tb.sv
